/* rtl/sdow_pkg.sv */
// Shared types and constants for the stereo downmix overlap windower.
// No dependencies; imported by sdow_store and the top level.
package sdow_pkg;

    localparam int CFG_W = 7;   // width of window_size / step_size
    localparam int FILL_W = 7;  // fill position and sample counter width
    localparam int POS_W = 6;   // width of the position output field

    typedef enum logic [0:0] {
        REG_WINDOW_SIZE = 1'b0,
        REG_STEP_SIZE   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // Clamp a window size into 2..maxw.
    function automatic logic [CFG_W-1:0] clamp_window(input logic [CFG_W-1:0] ws,
                                                      input logic [CFG_W-1:0] maxw);
        logic [CFG_W-1:0] r;
        if (ws < CFG_W'(2))
            r = CFG_W'(2);
        else if (ws > maxw)
            r = maxw;
        else
            r = ws;
        return r;
    endfunction

    // Clamp a step into 1..w.
    function automatic logic [CFG_W-1:0] clamp_step(input logic [CFG_W-1:0] ss,
                                                    input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] r;
        if (ss == '0)
            r = CFG_W'(1);
        else if (ss > w)
            r = w;
        else
            r = ss;
        return r;
    endfunction

endpackage

/* rtl/sdow_store.sv */
// Window sample store: one-port-write, one-port-read memory, registered read.
// Per-entry valid bits make never-written entries read as zero. Uses sdow_pkg.
module sdow_store
    import sdow_pkg::*;
#(
    parameter int AW = 6,
    parameter int DW = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
                valid_reg <= '0;
            else if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
                rvalid_reg <= valid_reg[raddr];
        end
    end

    // Unwritten entries hold the cleared value.
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* rtl/stereo_downmix_overlap_windower_core.sv */
// Top level of the stereo downmix overlap windower.
// Depends on sdow_pkg and sdow_store.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | kind, left_sample, right_sample
//   out     | out       | out_valid / out_ready | mono_sample, position, last
//
// An item that does not complete the window is only written to the store. The
// item that completes it starts a readout of every window sample, each as a
// memory read, then an output register load; the read waits while the
// consumer has not taken the previous result, and the read of one sample
// waits for the load of the one before it.
// Reset and every register write clear the store through per-entry valid
// bits, with no clearing pass. A stalled consumer holds the readout, and no
// item is taken until the window readout is complete.
module stereo_downmix_overlap_windower_core
    import sdow_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] mono_sample,
    output logic [POS_W-1:0]              position,
    output logic                          last
);

    // Physical store is a power-of-two ring so the slide is a base advance.
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_WINDOW);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  window_size_reg, window_size_next;
    logic [CFG_W-1:0]  step_size_reg, step_size_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [AW-1:0]     base_reg, base_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] mono_reg, mono_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   last_reg, last_next;

    logic [CFG_W-1:0]  eff_w, eff_s;
    logic [FILL_W-1:0] fill_w;
    logic              accept;
    logic              last_idx;
    logic              cfg_known;

    logic signed [SAMPLE_BITS:0] sum;
    logic [SAMPLE_BITS-1:0]      mono;

    logic                   st_we, st_re, st_clear;
    logic [AW-1:0]          st_waddr, st_raddr;
    logic [SAMPLE_BITS-1:0] st_rdata;

    assign eff_w = clamp_window(window_size_reg, MAX_W);
    assign eff_s = clamp_step(step_size_reg, eff_w);

    // Floor of the average: one extra bit, then drop the LSB.
    assign sum  = {left_sample[SAMPLE_BITS-1], left_sample}
                + {right_sample[SAMPLE_BITS-1], right_sample};
    assign mono = kind ? '0 : sum[SAMPLE_BITS:1];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fill_w   = (fill_reg >= FILL_W'(eff_w)) ? FILL_W'(eff_w) - FILL_W'(1) : fill_reg;
    assign last_idx = (idx_reg == FILL_W'(eff_w) - FILL_W'(1));

    sdow_store #(
        .AW (AW),
        .DW (SAMPLE_BITS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (st_clear),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (mono),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign st_we    = accept;
    assign st_waddr = base_reg + fill_w[AW-1:0];
    assign st_raddr = base_reg + idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= CFG_W'(64);
            step_size_reg   <= CFG_W'(32);
            fill_reg        <= FILL_W'(clamp_window(CFG_W'(64), MAX_W) >> 1);
            idx_reg         <= '0;
            base_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            step_size_reg   <= step_size_next;
            fill_reg        <= fill_next;
            idx_reg         <= idx_next;
            base_reg        <= base_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload holds without reset.
    always_ff @(posedge clk)
    begin
        mono_reg <= mono_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        step_size_next   = step_size_reg;
        fill_next        = fill_reg;
        idx_next         = idx_reg;
        base_next        = base_reg;
        out_valid_next   = out_valid_reg;
        mono_next        = mono_reg;
        pos_next         = pos_reg;
        last_next        = last_reg;
        st_re            = 1'b0;
        st_clear         = 1'b0;
        cfg_known        = 1'b0;

        // Drop the result once the consumer takes it.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_w + FILL_W'(1);
                    if (fill_w + FILL_W'(1) == FILL_W'(eff_w))
                    begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // Issue the read only when the output register is free next cycle.
                if (!out_valid_reg || out_ready)
                begin
                    st_re      = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                out_valid_next = 1'b1;
                mono_next      = st_rdata;
                pos_next       = POS_W'(idx_reg);
                last_next      = last_idx;
                if (last_idx)
                begin
                    // Slide the window: advance the ring base, pull the fill back.
                    base_next  = base_reg + eff_s[AW-1:0];
                    fill_next  = FILL_W'(eff_w) - FILL_W'(eff_s);
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write re-initializes the window, as at reset.
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:
                begin
                    window_size_next = cfg_data;
                    cfg_known        = 1'b1;
                end
                REG_STEP_SIZE:
                begin
                    step_size_next = cfg_data;
                    cfg_known      = 1'b1;
                end
                default:
                begin
                    cfg_known = 1'b0;
                end
            endcase
            if (cfg_known)
            begin
                st_clear  = 1'b1;
                base_next = '0;
                fill_next = FILL_W'(clamp_window(window_size_next, MAX_W) >> 1);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign mono_sample = mono_reg;
    assign position    = pos_reg;
    assign last        = last_reg;

    // The fill position never reaches the window while waiting for items.
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_W'(eff_w)))
        else $error("fill position out of window while idle");

    // Readout index stays inside the window.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_LOAD) |-> (idx_reg < FILL_W'(eff_w)))
        else $error("readout index out of window");

    // A load never overwrites a result that has not been taken.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !out_valid_reg)
        else $error("output register overwritten");

    // Loading the final sample returns to taking items, marked last.
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && last_idx) |=> (state_reg == ST_IDLE && last_reg && out_valid_reg))
        else $error("window readout did not close");

endmodule
